// File: design/phdt_pkg.sv
package phdt_pkg;

   // field widths
   localparam int OPCODE_W   = 2;
   localparam int STATUS_W   = 3;
   localparam int ID_W       = 8;
   localparam int PERIOD_W   = 16;
   localparam int ORDER_W    = 8;
   localparam int TICK_W     = 32;
   localparam int REQ_DATA_W = 2 * ID_W + PERIOD_W + ORDER_W;
   localparam int RSP_DATA_W = 2 * ID_W;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FIRE      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE_DUE  = 3'd4;

   // remainder unit: dividend bits retired per cycle
   localparam int REM_BITS  = 4;
   localparam int REM_STEPS = TICK_W / REM_BITS;
   localparam int STEP_W    = $clog2(REM_STEPS);

   // one table entry, client in the lowest bits (same layout as req tdata)
   typedef struct packed {
      logic signed [ORDER_W-1:0] order;
      logic [PERIOD_W-1:0]       period;
      logic [ID_W-1:0]           routine;
      logic [ID_W-1:0]           client;
   } entry_type;

   // remainder unit status
   typedef struct packed {
      logic done;
      logic is_zero;
   } rem_status_type;

endpackage

// File: design/phdt_rem.sv
module phdt_rem (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [phdt_pkg::TICK_W-1:0]     dividend,
   input  logic [phdt_pkg::PERIOD_W-1:0]   divisor,
   output phdt_pkg::rem_status_type        status
);
   import phdt_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [PERIOD_W-1:0] part_ff;
   logic [PERIOD_W-1:0] part_in;
   logic [TICK_W-1:0]   bits_ff;
   logic [TICK_W-1:0]   bits_in;
   logic [PERIOD_W-1:0] div_ff;

   // restoring remainder, a few dividend bits per cycle, msb first
   always_comb begin
      logic [PERIOD_W:0] trial;
      part_in = part_ff;
      bits_in = bits_ff;
      trial   = '0;
      for (int k = 0; k < REM_BITS; k++) begin
         trial   = {part_in, bits_in[TICK_W-1]};
         bits_in = {bits_in[TICK_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         part_in = trial[PERIOD_W-1:0];
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && step_ff == STEP_W'(REM_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         step_ff <= '0;
         part_ff <= '0;
         bits_ff <= dividend;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         step_ff <= step_ff + 1'b1;
         part_ff <= part_in;
         bits_ff <= bits_in;
      end
   end

   assign status.done    = done_ff;
   assign status.is_zero = (part_ff == '0);

endmodule

// File: design/periodic_handler_dispatch_table.sv
// Periodic handler dispatch table. Entries live in a one-port-read, one-port-write
// synchronous memory kept sorted by priority order; one item is worked on at a time
// and req_tready is high only between items. An add walks down from the top of the
// table moving larger orders up one slot; a remove scans from the bottom and then
// closes the gap. A tick with dispatch enabled reads each entry in turn and, for an
// entry with a nonzero period, runs the remainder unit (32-bit tick count by 16-bit
// period, four bits per cycle); a disabled tick goes straight to its result. Each
// result leaves through an output register and waits there while rsp_tready is low;
// fire results come out in table order, with rsp_tlast on the last one. The memory
// needs no clearing after reset, since only entries below the entry count are read.
module periodic_handler_dispatch_table #(
   parameter int TABLE_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // client_id, routine_id, period, priority_order
   input  logic [phdt_pkg::REQ_DATA_W-1:0]     req_tdata,
   // opcode
   input  logic [phdt_pkg::OPCODE_W-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // fired_client, fired_routine
   output logic [phdt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic [phdt_pkg::STATUS_W-1:0]       rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic                                csr_wdata
);
   import phdt_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_FINISH    = 4'd1;
   localparam logic [3:0] S_TICK_RD   = 4'd2;
   localparam logic [3:0] S_TICK_CHK  = 4'd3;
   localparam logic [3:0] S_TICK_WAIT = 4'd4;
   localparam logic [3:0] S_TICK_EMIT = 4'd5;
   localparam logic [3:0] S_ADD_STEP  = 4'd6;
   localparam logic [3:0] S_ADD_CHK   = 4'd7;
   localparam logic [3:0] S_RM_RD     = 4'd8;
   localparam logic [3:0] S_RM_CHK    = 4'd9;
   localparam logic [3:0] S_SHIFT_RD  = 4'd10;
   localparam logic [3:0] S_SHIFT_WR  = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic                en_ff;
   entry_type           new_ff, new_in;
   logic [STATUS_W-1:0] fin_ff, fin_in;
   logic                bump_ff, bump_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]     pend_client_ff, pend_client_in;
   logic [ID_W-1:0]     pend_routine_ff, pend_routine_in;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ID_W-1:0]     rsp_client_ff;
   logic [ID_W-1:0]     rsp_routine_ff;
   logic                rsp_last_ff;

   entry_type           mem [TABLE_DEPTH];
   entry_type           rd_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   entry_type           mem_wdata;
   logic [IDX_W-1:0]    mem_raddr;

   logic                rem_start;
   rem_status_type      rem_status;

   logic                emit;
   logic [STATUS_W-1:0] emit_status;
   logic [ID_W-1:0]     emit_client;
   logic [ID_W-1:0]     emit_routine;
   logic                emit_last;

   logic                out_free;
   logic [CNT_W-1:0]    idx_next;
   logic [CNT_W-1:0]    idx_prev;
   logic                scan_end;
   logic                id_match;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign idx_next   = idx_ff + 1'b1;
   assign idx_prev   = idx_ff - 1'b1;
   assign scan_end   = (idx_next == count_ff);
   assign id_match   = (rd_ff.client == new_ff.client) && (rd_ff.routine == new_ff.routine);
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   // modulo of the tick count by one entry's period
   phdt_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (tick_ff),
      .divisor  (rd_ff.period),
      .status   (rem_status)
   );

   // sequencer
   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      count_in        = count_ff;
      tick_in         = tick_ff;
      new_in          = new_ff;
      fin_in          = fin_ff;
      bump_in         = bump_ff;
      pend_valid_in   = pend_valid_ff;
      pend_client_in  = pend_client_ff;
      pend_routine_in = pend_routine_ff;
      mem_we          = 1'b0;
      mem_waddr       = idx_ff[IDX_W-1:0];
      mem_wdata       = new_ff;
      mem_raddr       = idx_ff[IDX_W-1:0];
      rem_start       = 1'b0;
      emit            = 1'b0;
      emit_status     = ST_ACCEPTED;
      emit_client     = '0;
      emit_routine    = '0;
      emit_last       = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               new_in        = entry_type'(req_tdata);
               pend_valid_in = 1'b0;
               bump_in       = 1'b0;
               fin_in        = ST_NONE_DUE;
               idx_in        = '0;
               unique case (req_tuser)
                  OP_TICK: begin
                     if (!en_ff) begin
                        state_in = S_FINISH;
                     end else begin
                        bump_in  = 1'b1;
                        state_in = (count_ff == '0) ? S_FINISH : S_TICK_RD;
                     end
                  end
                  OP_ADD: begin
                     if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                        fin_in   = ST_FULL;
                        state_in = S_FINISH;
                     end else begin
                        fin_in   = ST_ACCEPTED;
                        idx_in   = count_ff;
                        state_in = S_ADD_STEP;
                     end
                  end
                  OP_REMOVE: begin
                     fin_in   = ST_NOT_FOUND;
                     state_in = (count_ff == '0) ? S_FINISH : S_RM_RD;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         // tick: read entry, test period, run remainder
         S_TICK_RD: begin
            state_in = S_TICK_CHK;
         end
         S_TICK_CHK: begin
            if (rd_ff.period != '0) begin
               rem_start = 1'b1;
               state_in  = S_TICK_WAIT;
            end else if (scan_end) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = idx_next;
               state_in = S_TICK_RD;
            end
         end
         S_TICK_WAIT: begin
            if (rem_status.done) begin
               if (rem_status.is_zero && pend_valid_ff) begin
                  state_in = S_TICK_EMIT;
               end else begin
                  if (rem_status.is_zero) begin
                     pend_valid_in   = 1'b1;
                     pend_client_in  = rd_ff.client;
                     pend_routine_in = rd_ff.routine;
                  end
                  if (scan_end) begin
                     state_in = S_FINISH;
                  end else begin
                     idx_in   = idx_next;
                     state_in = S_TICK_RD;
                  end
               end
            end
         end
         // a new firing entry is due: the held one is not the last
         S_TICK_EMIT: begin
            if (out_free) begin
               emit            = 1'b1;
               emit_status     = ST_FIRE;
               emit_client     = pend_client_ff;
               emit_routine    = pend_routine_ff;
               emit_last       = 1'b0;
               pend_client_in  = rd_ff.client;
               pend_routine_in = rd_ff.routine;
               if (scan_end) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_next;
                  state_in = S_TICK_RD;
               end
            end
         end

         // add: move larger orders up one slot, from the top down
         S_ADD_STEP: begin
            if (idx_ff == '0) begin
               mem_we   = 1'b1;
               count_in = count_ff + 1'b1;
               state_in = S_FINISH;
            end else begin
               mem_raddr = idx_prev[IDX_W-1:0];
               state_in  = S_ADD_CHK;
            end
         end
         S_ADD_CHK: begin
            mem_we = 1'b1;
            if (new_ff.order < rd_ff.order) begin
               mem_wdata = rd_ff;
               idx_in    = idx_prev;
               state_in  = S_ADD_STEP;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = S_FINISH;
            end
         end

         // remove: find first match, then close the gap
         S_RM_RD: begin
            state_in = S_RM_CHK;
         end
         S_RM_CHK: begin
            if (id_match) begin
               fin_in   = ST_ACCEPTED;
               state_in = S_SHIFT_RD;
            end else if (scan_end) begin
               state_in = S_FINISH;
            end else begin
               idx_in   = idx_next;
               state_in = S_RM_RD;
            end
         end
         S_SHIFT_RD: begin
            if (scan_end) begin
               count_in = count_ff - 1'b1;
               state_in = S_FINISH;
            end else begin
               mem_raddr = idx_next[IDX_W-1:0];
               state_in  = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_ff;
            idx_in    = idx_next;
            state_in  = S_SHIFT_RD;
         end

         // final result of the item
         S_FINISH: begin
            if (out_free) begin
               emit = 1'b1;
               if (pend_valid_ff) begin
                  emit_status  = ST_FIRE;
                  emit_client  = pend_client_ff;
                  emit_routine = pend_routine_ff;
               end else begin
                  emit_status = fin_ff;
               end
               if (bump_ff) begin
                  tick_in = tick_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         tick_ff       <= '0;
         en_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         tick_ff       <= tick_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_valid && csr_ready) begin
            en_ff <= csr_wdata;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      new_ff          <= new_in;
      fin_ff          <= fin_in;
      bump_ff         <= bump_in;
      pend_client_ff  <= pend_client_in;
      pend_routine_ff <= pend_routine_in;
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[mem_raddr];
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff  <= emit_status;
         rsp_client_ff  <= emit_client;
         rsp_routine_ff <= emit_routine;
         rsp_last_ff    <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_routine_ff, rsp_client_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: design/phdt_checker.sv
module phdt_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [phdt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [phdt_pkg::STATUS_W-1:0]       rsp_tuser,
   input logic                                rsp_tlast
);
   import phdt_pkg::*;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // only fire results carry ids, and every other result closes its item
   a_plain_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_FIRE |-> rsp_tlast && rsp_tdata == '0)
      else $error("non-fire result with ids or without last");

   // no new item is taken while a non-final fire result is taken
   a_busy_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |-> !req_tready)
      else $error("item accepted while a tick is still firing");

endmodule

bind periodic_handler_dispatch_table phdt_checker u_phdt_checker (.*);
